// ===== rtl/tbgc_pkg.sv =====
// ----------------------------------------------------------------------------
// tbgc_pkg
// Shared types and constants of the three-button gesture controller:
// register indexes, register reset values, action and player state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tbgc_pkg;

   localparam int TimeWidthDefault   = 63;
   localparam int MaxStationsDefault = 8;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 24;
   localparam int TimeCfgWidth  = 24;
   localparam int StepCfgWidth  = 8;
   localparam int CountWidth    = 4;
   localparam int StationWidth  = 3;
   localparam int StepWidth     = 9;
   localparam int PlayerWidth   = 3;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_LONG_PRESS      = 3'd0,
      CSR_REPEAT_DELAY    = 3'd1,
      CSR_REPEAT_INTERVAL = 3'd2,
      CSR_IDLE_EXIT       = 3'd3,
      CSR_COARSE_STEP     = 3'd4,
      CSR_FINE_STEP       = 3'd5,
      CSR_STATION_COUNT   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_START = 2'd1,
      ACT_STOP  = 2'd2
   } action_type;

   localparam logic [PlayerWidth-1:0] PLAYER_STOPPED = 3'd0;
   localparam logic [PlayerWidth-1:0] PLAYER_ERROR   = 3'd4;

   localparam logic [TimeCfgWidth-1:0] LongPressReset      = 24'd600000;
   localparam logic [TimeCfgWidth-1:0] RepeatDelayReset    = 24'd400000;
   localparam logic [TimeCfgWidth-1:0] RepeatIntervalReset = 24'd120000;
   localparam logic [TimeCfgWidth-1:0] IdleExitReset       = 24'd5000000;
   localparam logic [StepCfgWidth-1:0] CoarseStepReset     = 8'd16;
   localparam logic [StepCfgWidth-1:0] FineStepReset       = 8'd8;
   localparam logic [CountWidth-1:0]   StationCountReset   = 4'd5;

   localparam logic [StepCfgWidth-1:0] StepLimit = 8'd128;

   function automatic logic [StepCfgWidth-1:0] sat_step(input logic [StepCfgWidth-1:0] v);
      sat_step = (v > StepLimit) ? StepLimit : v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/three_button_gesture_controller.sv =====
// ----------------------------------------------------------------------------
// three_button_gesture_controller
// Turns button poll samples into play/stop actions, volume step requests and
// station moves, with long-press volume mode, auto-repeat and idle exit.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one poll sample per beat (timestamp, three button levels,
//   player state); rsp_* carries exactly one result beat per sample.
//   Both channels use valid/stall; a beat moves when valid is high and stall
//   is low. csr_we writes csr_wdata to register csr_index; indexes beyond
//   the register list are dropped. Write registers only
//   while no sample is in flight.
//   Latency: the result of a sample is on rsp_* the cycle after its req
//   beat. Throughput: one sample per cycle while the receiver does not stall,
//   set by the single output register stage behind the gesture logic.
//   A stalled result holds its register; req_stall rises only while a result
//   waits and the receiver stalls, so a new sample is taken in the same
//   cycle the waiting result leaves.
//   Reset (synchronous, active high) clears button history, timestamps,
//   volume mode and the station index, and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module three_button_gesture_controller #(
   parameter int TIME_WIDTH   = tbgc_pkg::TimeWidthDefault,
   parameter int MAX_STATIONS = tbgc_pkg::MaxStationsDefault
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [tbgc_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [tbgc_pkg::CsrDataWidth-1:0]     csr_wdata,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [TIME_WIDTH-1:0]                 req_now_us,
   input  wire logic                                  req_left_pressed,
   input  wire logic                                  req_middle_pressed,
   input  wire logic                                  req_right_pressed,
   input  wire logic [tbgc_pkg::PlayerWidth-1:0]      req_player_state,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [1:0]                                 rsp_action,
   output logic signed [tbgc_pkg::StepWidth-1:0]      rsp_volume_step,
   output logic [tbgc_pkg::StationWidth-1:0]          rsp_station,
   output logic                                       rsp_volume_mode,
   output logic                                       rsp_station_changed
);

   import tbgc_pkg::*;

   localparam int CountMax = (1 << CountWidth) - 1;
   localparam logic [CountWidth-1:0] MaxCount =
      CountWidth'((MAX_STATIONS > CountMax) ? CountMax : MAX_STATIONS);
   localparam int IdxWidth = (MAX_STATIONS > CountMax) ? CountWidth : $clog2(MAX_STATIONS);
   localparam int SumWidth = CountWidth + 1;

   // configuration
   logic [TimeCfgWidth-1:0] long_press_ff, repeat_delay_ff, repeat_interval_ff, idle_exit_ff;
   logic [StepCfgWidth-1:0] coarse_step_ff, fine_step_ff;
   logic [CountWidth-1:0]   station_count_ff;

   // gesture state
   logic                  left_prev_ff, middle_prev_ff, right_prev_ff;
   logic                  long_fired_ff, volume_mode_ff;
   logic [TIME_WIDTH-1:0] middle_down_ff, last_activity_ff, left_down_ff;
   logic [TIME_WIDTH-1:0] right_down_ff, last_repeat_ff;
   logic [IdxWidth-1:0]   station_ff;

   logic                  long_fired_in, volume_mode_in;
   logic [TIME_WIDTH-1:0] middle_down_in, last_activity_in, left_down_in;
   logic [TIME_WIDTH-1:0] right_down_in, last_repeat_in;
   logic [IdxWidth-1:0]   station_in;

   // result register
   logic                        rsp_valid_ff;
   logic [1:0]                  rsp_action_ff, rsp_action_in;
   logic signed [StepWidth-1:0] rsp_step_ff, rsp_step_in;
   logic [StationWidth-1:0]     rsp_station_ff, rsp_station_in;
   logic                        rsp_mode_ff, rsp_mode_in;
   logic                        rsp_changed_ff, rsp_changed_in;

   logic accept;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // --- gesture logic ---
   logic                    m_edge, l_edge, r_edge, lf_eff, long_hit, lf_new, rel;
   logic                    vm_a, vm_b, act_mid, any_lr, rep_hit, step_nz, activity, idle_hit;
   logic [TIME_WIDTH-1:0]   md_el, down_el, rep_el, idle_el;
   logic [StepCfgWidth-1:0] coarse_mag, fine_mag;
   logic signed [StepWidth-1:0] coarse_val, step_val;
   action_type              action;
   logic [CountWidth-1:0]   cnt_eff, addend;
   logic [SumWidth-1:0]     sum, rem;
   logic [IdxWidth+StationWidth-1:0] station_ext;

   always_comb begin
      m_edge  = req_middle_pressed & ~middle_prev_ff;
      l_edge  = req_left_pressed & ~left_prev_ff;
      r_edge  = req_right_pressed & ~right_prev_ff;

      lf_eff   = m_edge ? 1'b0 : long_fired_ff;
      md_el    = m_edge ? '0 : (req_now_us - middle_down_ff);
      long_hit = req_middle_pressed & ~lf_eff & (md_el > TIME_WIDTH'(long_press_ff));
      lf_new   = lf_eff | long_hit;
      vm_a     = volume_mode_ff ^ long_hit;
      rel      = ~req_middle_pressed & middle_prev_ff & ~lf_new;

      action = ACT_NONE;
      vm_b   = vm_a;
      if (rel) begin
         if (vm_a) begin
            vm_b = 1'b0;
         end else if (req_player_state == PLAYER_STOPPED ||
                      req_player_state == PLAYER_ERROR) begin
            action = ACT_START;
         end else begin
            action = ACT_STOP;
         end
      end
      act_mid = long_hit | rel;

      // volume mode
      coarse_mag = sat_step(coarse_step_ff);
      fine_mag   = sat_step(fine_step_ff);
      coarse_val = '0;
      if (r_edge) begin
         coarse_val = $signed({1'b0, coarse_mag});
      end else if (l_edge) begin
         coarse_val = -$signed({1'b0, coarse_mag});
      end
      any_lr = req_left_pressed | req_right_pressed;
      if (req_left_pressed) begin
         down_el = l_edge ? '0 : (req_now_us - left_down_ff);
      end else begin
         down_el = r_edge ? '0 : (req_now_us - right_down_ff);
      end
      rep_el  = req_now_us - last_repeat_ff;
      rep_hit = vm_b & (coarse_val == '0) & any_lr
                & (down_el > TIME_WIDTH'(repeat_delay_ff))
                & (rep_el > TIME_WIDTH'(repeat_interval_ff));
      step_val = coarse_val;
      if (rep_hit) begin
         step_val = req_left_pressed ? -$signed({1'b0, fine_mag})
                                     :  $signed({1'b0, fine_mag});
      end
      if (!vm_b) begin
         step_val = '0;
      end
      step_nz  = (step_val != '0);
      activity = act_mid | step_nz;
      idle_el  = activity ? '0 : (req_now_us - last_activity_ff);
      idle_hit = vm_b & (idle_el > TIME_WIDTH'(idle_exit_ff));

      // station move: restoring remainder over the narrow sum
      if (station_count_ff == '0) begin
         cnt_eff = CountWidth'(1);
      end else if (station_count_ff > MaxCount) begin
         cnt_eff = MaxCount;
      end else begin
         cnt_eff = station_count_ff;
      end
      addend = r_edge ? CountWidth'(1) : (cnt_eff - CountWidth'(1));
      sum    = SumWidth'(station_ff) + SumWidth'(addend);
      rem    = '0;
      for (int i = SumWidth - 1; i >= 0; i--) begin
         rem = {rem[SumWidth-2:0], sum[i]};
         if (rem >= SumWidth'(cnt_eff)) begin
            rem = rem - SumWidth'(cnt_eff);
         end
      end

      station_in     = station_ff;
      rsp_changed_in = 1'b0;
      if (!vm_b && (l_edge || r_edge)) begin
         station_in     = IdxWidth'(rem);
         rsp_changed_in = 1'b1;
         action         = ACT_START;
      end

      long_fired_in    = lf_new;
      volume_mode_in   = vm_b & ~idle_hit;
      middle_down_in   = m_edge ? req_now_us : middle_down_ff;
      left_down_in     = l_edge ? req_now_us : left_down_ff;
      right_down_in    = r_edge ? req_now_us : right_down_ff;
      last_repeat_in   = rep_hit ? req_now_us : last_repeat_ff;
      last_activity_in = activity ? req_now_us : last_activity_ff;

      station_ext    = {{StationWidth{1'b0}}, station_in};
      rsp_action_in  = action;
      rsp_step_in    = step_val;
      rsp_station_in = station_ext[StationWidth-1:0];
      rsp_mode_in    = volume_mode_in;
   end

   // --- configuration registers ---
   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff      <= LongPressReset;
         repeat_delay_ff    <= RepeatDelayReset;
         repeat_interval_ff <= RepeatIntervalReset;
         idle_exit_ff       <= IdleExitReset;
         coarse_step_ff     <= CoarseStepReset;
         fine_step_ff       <= FineStepReset;
         station_count_ff   <= StationCountReset;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LONG_PRESS:      long_press_ff      <= csr_wdata[TimeCfgWidth-1:0];
            CSR_REPEAT_DELAY:    repeat_delay_ff    <= csr_wdata[TimeCfgWidth-1:0];
            CSR_REPEAT_INTERVAL: repeat_interval_ff <= csr_wdata[TimeCfgWidth-1:0];
            CSR_IDLE_EXIT:       idle_exit_ff       <= csr_wdata[TimeCfgWidth-1:0];
            CSR_COARSE_STEP:     coarse_step_ff     <= csr_wdata[StepCfgWidth-1:0];
            CSR_FINE_STEP:       fine_step_ff       <= csr_wdata[StepCfgWidth-1:0];
            CSR_STATION_COUNT:   station_count_ff   <= csr_wdata[CountWidth-1:0];
            default: ;
         endcase
      end
   end

   // --- gesture state, advance on each accepted sample ---
   always_ff @(posedge clock) begin
      if (reset) begin
         left_prev_ff     <= 1'b0;
         middle_prev_ff   <= 1'b0;
         right_prev_ff    <= 1'b0;
         long_fired_ff    <= 1'b0;
         volume_mode_ff   <= 1'b0;
         middle_down_ff   <= '0;
         last_activity_ff <= '0;
         left_down_ff     <= '0;
         right_down_ff    <= '0;
         last_repeat_ff   <= '0;
         station_ff       <= '0;
      end else if (accept) begin
         left_prev_ff     <= req_left_pressed;
         middle_prev_ff   <= req_middle_pressed;
         right_prev_ff    <= req_right_pressed;
         long_fired_ff    <= long_fired_in;
         volume_mode_ff   <= volume_mode_in;
         middle_down_ff   <= middle_down_in;
         last_activity_ff <= last_activity_in;
         left_down_ff     <= left_down_in;
         right_down_ff    <= right_down_in;
         last_repeat_ff   <= last_repeat_in;
         station_ff       <= station_in;
      end
   end

   // --- result register, hold while stalled ---
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_action_ff  <= rsp_action_in;
         rsp_step_ff    <= rsp_step_in;
         rsp_station_ff <= rsp_station_in;
         rsp_mode_ff    <= rsp_mode_in;
         rsp_changed_ff <= rsp_changed_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_action          = rsp_action_ff;
   assign rsp_volume_step     = rsp_step_ff;
   assign rsp_station         = rsp_station_ff;
   assign rsp_volume_mode     = rsp_mode_ff;
   assign rsp_station_changed = rsp_changed_ff;

endmodule

`default_nettype wire

// ===== bench/three_button_gesture_controller_tb.sv =====
// ----------------------------------------------------------------------------
// three_button_gesture_controller_tb
// Drives button poll samples into the gesture controller and checks every
// result beat against a cycle-free model of the gesture rules kept in this
// bench: long and short middle presses, volume mode with coarse, fine and
// auto-repeat steps, idle exit and station moves with wrap-around. Directed
// sequences come first, then register corner cases, a long receiver hold-off,
// and phases of random gesture sequences under different register settings,
// with random idle cycles on both channels except in one steady-flow phase.
// ----------------------------------------------------------------------------

module three_button_gesture_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tbgc_pkg::*;

   localparam int TW            = TimeWidthDefault;
   localparam int HoldOffCycles = 200;
   localparam int PhasePolls    = 250;
   localparam int PollTarget    = 1900;
   localparam int DrainLimit    = 1000;

   localparam logic [CsrIndexWidth-1:0] CsrSpareIndex = 3'd7;
   localparam logic [PlayerWidth-1:0]   PlayerPlaying = 3'd3;
   localparam logic [PlayerWidth-1:0]   PlayerUnknown = 3'd6;

   typedef struct {
      action_type                  action;
      logic signed [StepWidth-1:0] volume_step;
      logic [StationWidth-1:0]     station;
      logic                        volume_mode;
      logic                        station_changed;
   } poll_outcome_type;

   typedef struct {
      logic [CsrDataWidth-1:0] long_press;
      logic [CsrDataWidth-1:0] repeat_delay;
      logic [CsrDataWidth-1:0] repeat_gap;
      logic [CsrDataWidth-1:0] idle_exit;
      logic [CsrDataWidth-1:0] coarse;
      logic [CsrDataWidth-1:0] fine;
      logic [CsrDataWidth-1:0] count;
   } csr_image_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              csr_we = 1'b0;
   logic [CsrIndexWidth-1:0]          csr_index = '0;
   logic [CsrDataWidth-1:0]           csr_wdata = '0;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [TW-1:0]                     req_now_us = '0;
   logic                              req_left_pressed = 1'b0;
   logic                              req_middle_pressed = 1'b0;
   logic                              req_right_pressed = 1'b0;
   logic [PlayerWidth-1:0]            req_player_state = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [1:0]                        rsp_action;
   logic signed [StepWidth-1:0]       rsp_volume_step;
   logic [StationWidth-1:0]           rsp_station;
   logic                              rsp_volume_mode;
   logic                              rsp_station_changed;

   // gesture model state
   logic                    prev_left, prev_middle, prev_right;
   logic                    long_press_done, in_volume_mode;
   logic [TW-1:0]           middle_press_at, activity_at;
   logic [TW-1:0]           left_press_at, right_press_at, repeat_at;
   logic [StationWidth-1:0] station_sel;
   logic [TimeCfgWidth-1:0] long_press_cfg, repeat_delay_cfg, repeat_gap_cfg, idle_exit_cfg;
   logic [StepCfgWidth-1:0] coarse_cfg, fine_cfg;
   logic [CountWidth-1:0]   count_cfg;

   poll_outcome_type due_outcomes[$];
   int unsigned   mismatches = 0;
   int unsigned   polls_sent = 0;
   logic [TW-1:0] poll_now = '0;
   bit            steady_flow = 1'b0;
   bit            hold_off_pending = 1'b0;

   three_button_gesture_controller uut (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_now_us          (req_now_us),
      .req_left_pressed    (req_left_pressed),
      .req_middle_pressed  (req_middle_pressed),
      .req_right_pressed   (req_right_pressed),
      .req_player_state    (req_player_state),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_action          (rsp_action),
      .rsp_volume_step     (rsp_volume_step),
      .rsp_station         (rsp_station),
      .rsp_volume_mode     (rsp_volume_mode),
      .rsp_station_changed (rsp_station_changed)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic reset_gesture_model();
      prev_left        = 1'b0;
      prev_middle      = 1'b0;
      prev_right       = 1'b0;
      long_press_done  = 1'b0;
      in_volume_mode   = 1'b0;
      middle_press_at  = '0;
      activity_at      = '0;
      left_press_at    = '0;
      right_press_at   = '0;
      repeat_at        = '0;
      station_sel      = '0;
      long_press_cfg   = LongPressReset;
      repeat_delay_cfg = RepeatDelayReset;
      repeat_gap_cfg   = RepeatIntervalReset;
      idle_exit_cfg    = IdleExitReset;
      coarse_cfg       = CoarseStepReset;
      fine_cfg         = FineStepReset;
      count_cfg        = StationCountReset;
   endtask

   function automatic logic [TW-1:0] since(input logic [TW-1:0] now_us,
                                           input logic [TW-1:0] past_us);
      return now_us - past_us;
   endfunction

   function automatic logic signed [StepWidth-1:0] step_size(input logic [StepCfgWidth-1:0] mag);
      return (mag > 8'd128) ? 9'sd128 : $signed({1'b0, mag});
   endfunction

   function automatic logic [TW-1:0] rand_dt(input int unsigned limit);
      return TW'($urandom_range(limit));
   endfunction

   function automatic logic [PlayerWidth-1:0] rand_player();
      return PlayerWidth'($urandom_range(7));
   endfunction

   function automatic bit rand_bit();
      return 1'($urandom_range(1));
   endfunction

   function automatic poll_outcome_type predict_outcome(input logic [TW-1:0] now_us,
                                                        input logic left, middle, right,
                                                        input logic [PlayerWidth-1:0] player);
      poll_outcome_type       res;
      logic                   left_edge, right_edge;
      logic [TW-1:0]          held_at;
      logic [CountWidth-1:0]  wrap;
      int                     next_sel;
      res.action          = ACT_NONE;
      res.volume_step     = '0;
      res.station_changed = 1'b0;
      if (middle && !prev_middle) begin
         middle_press_at = now_us;
         long_press_done = 1'b0;
      end
      if (middle && !long_press_done && since(now_us, middle_press_at) > long_press_cfg) begin
         long_press_done = 1'b1;
         in_volume_mode  = !in_volume_mode;
         activity_at     = now_us;
      end
      if (!middle && prev_middle && !long_press_done) begin
         if (in_volume_mode)
            in_volume_mode = 1'b0;
         else if (player == PLAYER_STOPPED || player == PLAYER_ERROR)
            res.action = ACT_START;
         else
            res.action = ACT_STOP;
         activity_at = now_us;
      end
      left_edge  = left && !prev_left;
      right_edge = right && !prev_right;
      if (left_edge)
         left_press_at = now_us;
      if (right_edge)
         right_press_at = now_us;
      if (in_volume_mode) begin
         if (left_edge)
            res.volume_step = -step_size(coarse_cfg);
         if (right_edge)
            res.volume_step = step_size(coarse_cfg);
         held_at = left ? left_press_at : right_press_at;
         if (res.volume_step == 0 && (left || right)
               && since(now_us, held_at) > repeat_delay_cfg
               && since(now_us, repeat_at) > repeat_gap_cfg) begin
            res.volume_step = left ? -step_size(fine_cfg) : step_size(fine_cfg);
            repeat_at = now_us;
         end
         if (res.volume_step != 0)
            activity_at = now_us;
         if (since(now_us, activity_at) > idle_exit_cfg)
            in_volume_mode = 1'b0;
      end else if (left_edge || right_edge) begin
         if (count_cfg == '0)
            wrap = 4'd1;
         else if (count_cfg > 4'(MaxStationsDefault))
            wrap = 4'(MaxStationsDefault);
         else
            wrap = count_cfg;
         next_sel = (int'(station_sel) + (right_edge ? 1 : int'(wrap) - 1)) % int'(wrap);
         station_sel         = next_sel[StationWidth-1:0];
         res.station_changed = 1'b1;
         res.action          = ACT_START;
      end
      prev_left   = left;
      prev_middle = middle;
      prev_right  = right;
      res.station     = station_sel;
      res.volume_mode = in_volume_mode;
      return res;
   endfunction

   always @(posedge clock) begin : outcome_check
      poll_outcome_type due;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (due_outcomes.size() == 0) begin
               $error("result beat with no sample pending");
               mismatches++;
            end else begin
               due = due_outcomes.pop_front();
               if (rsp_action !== due.action) begin
                  $error("action: expected %0d, got %0d", due.action, rsp_action);
                  mismatches++;
               end
               if (rsp_volume_step !== due.volume_step) begin
                  $error("volume_step: expected %0d, got %0d", due.volume_step,
                         rsp_volume_step);
                  mismatches++;
               end
               if (rsp_station !== due.station) begin
                  $error("station: expected %0d, got %0d", due.station, rsp_station);
                  mismatches++;
               end
               if (rsp_volume_mode !== due.volume_mode) begin
                  $error("volume_mode: expected %0d, got %0d", due.volume_mode,
                         rsp_volume_mode);
                  mismatches++;
               end
               if (rsp_station_changed !== due.station_changed) begin
                  $error("station_changed: expected %0d, got %0d", due.station_changed,
                         rsp_station_changed);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall)
            due_outcomes.push_back(predict_outcome(req_now_us, req_left_pressed,
                                                   req_middle_pressed, req_right_pressed,
                                                   req_player_state));
      end
   end

   initial begin : result_sink
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HoldOffCycles) @(posedge clock);
         end
         rsp_stall <= !steady_flow && ($urandom_range(99) < 19);
      end
   end

   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_LONG_PRESS:      long_press_cfg   = data;
         CSR_REPEAT_DELAY:    repeat_delay_cfg = data;
         CSR_REPEAT_INTERVAL: repeat_gap_cfg   = data;
         CSR_IDLE_EXIT:       idle_exit_cfg    = data;
         CSR_COARSE_STEP:     coarse_cfg       = data[StepCfgWidth-1:0];
         CSR_FINE_STEP:       fine_cfg         = data[StepCfgWidth-1:0];
         CSR_STATION_COUNT:   count_cfg        = data[CountWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic load_csr(input csr_image_type img);
      write_csr(CSR_LONG_PRESS, img.long_press);
      write_csr(CSR_REPEAT_DELAY, img.repeat_delay);
      write_csr(CSR_REPEAT_INTERVAL, img.repeat_gap);
      write_csr(CSR_IDLE_EXIT, img.idle_exit);
      write_csr(CSR_COARSE_STEP, img.coarse);
      write_csr(CSR_FINE_STEP, img.fine);
      write_csr(CSR_STATION_COUNT, img.count);
      write_csr(CsrSpareIndex, 24'($urandom));
      csr_we <= 1'b0;
   endtask

   function automatic csr_image_type default_image();
      csr_image_type img;
      img.long_press   = LongPressReset;
      img.repeat_delay = RepeatDelayReset;
      img.repeat_gap   = RepeatIntervalReset;
      img.idle_exit    = IdleExitReset;
      img.coarse       = CsrDataWidth'(CoarseStepReset);
      img.fine         = CsrDataWidth'(FineStepReset);
      img.count        = CsrDataWidth'(StationCountReset);
      return img;
   endfunction

   task automatic poll(input bit left, middle, right, input logic [TW-1:0] dt,
                       input logic [PlayerWidth-1:0] player);
      poll_now = poll_now + dt;
      while (!steady_flow && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_now_us         <= poll_now;
      req_left_pressed   <= left;
      req_middle_pressed <= middle;
      req_right_pressed  <= right;
      req_player_state   <= player;
      do @(posedge clock); while (req_stall);
      polls_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_outcomes.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic gesture(input int unsigned tick);
      bit          l, r;
      int unsigned kind;
      kind = $urandom_range(9);
      l    = rand_bit();
      r    = !l || ($urandom_range(3) == 0);
      case (kind)
         0, 1: begin
            poll(0, 1, 0, rand_dt(2 * tick), rand_player());
            poll(0, 0, 0, rand_dt(tick), rand_player());
         end
         2: begin
            poll(0, 1, 0, rand_dt(2 * tick), rand_player());
            repeat ($urandom_range(12, 1))
               poll(0, 1, 0, rand_dt(2 * tick), rand_player());
            poll(0, 0, 0, rand_dt(2 * tick), rand_player());
         end
         3, 4: begin
            poll(l, 0, r, rand_dt(2 * tick), rand_player());
            poll(0, 0, 0, rand_dt(2 * tick), rand_player());
         end
         5, 6: begin
            poll(l, 0, r, rand_dt(2 * tick), rand_player());
            repeat ($urandom_range(10, 1))
               poll(l, 0, r, rand_dt(2 * tick), rand_player());
            poll(0, 0, 0, rand_dt(2 * tick), rand_player());
         end
         7: poll(0, 0, 0, rand_dt(2 * idle_exit_cfg + 1), rand_player());
         8: begin
            repeat ($urandom_range(6, 1))
               poll(rand_bit(), rand_bit(), rand_bit(),
                    ($urandom_range(4) == 0) ? TW'({$urandom, $urandom})
                                             : rand_dt(2 * tick),
                    rand_player());
         end
         default: begin
            poll(0, 1, 0, rand_dt(2 * tick), rand_player());
            poll(l, 1, r, rand_dt(2 * tick), rand_player());
            poll(l, 0, r, rand_dt(2 * tick), rand_player());
            poll(0, 0, 0, rand_dt(2 * tick), rand_player());
         end
      endcase
   endtask

   task automatic test_volume_mode();
      poll(0, 1, 0, 100000, PLAYER_STOPPED);
      poll(0, 1, 0, 650000, PLAYER_STOPPED);
      poll(0, 0, 0, 30000, PLAYER_STOPPED);
      poll(1, 0, 0, 30000, PLAYER_STOPPED);
      poll(1, 0, 0, 450000, PLAYER_STOPPED);
      poll(1, 0, 1, 30000, PLAYER_STOPPED);
      poll(1, 0, 1, 150000, PLAYER_STOPPED);
      poll(0, 0, 0, 30000, PLAYER_STOPPED);
      poll(0, 1, 0, 30000, PlayerPlaying);
      poll(0, 0, 0, 30000, PlayerPlaying);
      poll(0, 1, 0, 30000, PLAYER_STOPPED);
      poll(0, 1, 0, 700000, PLAYER_STOPPED);
      poll(0, 0, 0, 30000, PLAYER_STOPPED);
      poll(0, 0, 0, 5100000, PLAYER_STOPPED);
   endtask

   task automatic test_play_and_station();
      poll(0, 1, 0, 30000, PLAYER_STOPPED);
      poll(0, 0, 0, 30000, PLAYER_STOPPED);
      poll(0, 1, 0, 30000, PlayerPlaying);
      poll(0, 0, 0, 30000, PlayerPlaying);
      poll(0, 1, 0, 30000, PLAYER_ERROR);
      poll(0, 0, 0, 30000, PLAYER_ERROR);
      poll(0, 1, 0, 30000, PlayerUnknown);
      poll(0, 0, 0, 30000, PlayerUnknown);
      poll(1, 0, 0, 30000, PlayerPlaying);
      poll(0, 0, 0, 30000, PlayerPlaying);
      poll(0, 0, 1, 30000, PlayerPlaying);
      poll(0, 0, 0, 30000, PlayerPlaying);
      poll(1, 0, 1, 30000, PlayerPlaying);
      poll(0, 0, 0, 30000, PlayerPlaying);
      poll(0, 1, 0, 30000, PlayerPlaying);
      poll(0, 0, 1, 30000, PlayerPlaying);
      poll(0, 0, 0, 30000, PlayerPlaying);
   endtask

   task automatic test_time_wrap();
      poll_now = '1 - TW'(20000);
      poll(0, 1, 0, 5000, PlayerPlaying);
      poll(0, 1, 0, 30000, PlayerPlaying);
      poll(0, 0, 0, 30000, PlayerPlaying);
      poll(0, 1, 0, 30000, PlayerPlaying);
      poll(0, 1, 0, TW'(-1000), PlayerPlaying);
      poll(0, 0, 0, 30000, PlayerPlaying);
      poll(0, 1, 0, 30000, PlayerPlaying);
      poll(0, 0, 0, 30000, PlayerPlaying);
   endtask

   task automatic test_register_corners();
      csr_image_type img;
      settle();
      img.long_press   = '0;
      img.repeat_delay = '0;
      img.repeat_gap   = '0;
      img.idle_exit    = '1;
      img.coarse       = 24'hABCDC8;
      img.fine         = 24'h123400;
      img.count        = 24'h00000F;
      load_csr(img);
      poll(0, 1, 0, 1000, PLAYER_STOPPED);
      poll(0, 1, 0, 1000, PLAYER_STOPPED);
      poll(0, 0, 0, 1000, PLAYER_STOPPED);
      poll(1, 0, 0, 1000, PLAYER_STOPPED);
      poll(1, 0, 0, 1000, PLAYER_STOPPED);
      poll(0, 0, 0, 20000000, PLAYER_STOPPED);
      poll(1, 0, 0, 1000, PLAYER_STOPPED);
      poll(0, 0, 0, 1000, PLAYER_STOPPED);
      settle();
      img.count = 24'hFFFFF1;
      load_csr(img);
      poll(0, 0, 1, 1000, PlayerPlaying);
      poll(0, 0, 0, 1000, PlayerPlaying);
      settle();
      img.count = '0;
      load_csr(img);
      poll(1, 0, 0, 1000, PlayerPlaying);
      poll(0, 0, 0, 1000, PlayerPlaying);
   endtask

   task automatic test_backpressure();
      settle();
      load_csr(default_image());
      hold_off_pending = 1'b1;
      repeat (15) gesture(30000);
   endtask

   task automatic test_random_gestures();
      csr_image_type img;
      int unsigned   tick, phase_end;
      int            phase;
      phase = 0;
      while (polls_sent < PollTarget) begin
         settle();
         tick = $urandom_range(50000, 1000);
         case (phase)
            0: begin
               img  = default_image();
               tick = 30000;
            end
            1: begin
               img = '{default: '0};
               tick = 20000;
            end
            2: begin
               img = '{default: '1};
               tick = 2000000;
            end
            default: begin
               img.long_press   = CsrDataWidth'($urandom_range(8 * tick));
               img.repeat_delay = CsrDataWidth'($urandom_range(6 * tick));
               img.repeat_gap   = CsrDataWidth'($urandom_range(3 * tick));
               img.idle_exit    = CsrDataWidth'($urandom_range(30 * tick));
               img.coarse       = CsrDataWidth'(($urandom_range(3) == 0) ? $urandom
                                                                         : $urandom_range(40));
               img.fine         = CsrDataWidth'(($urandom_range(3) == 0) ? $urandom
                                                                         : $urandom_range(20));
               img.count        = 24'($urandom);
            end
         endcase
         load_csr(img);
         steady_flow = (phase == 3);
         phase_end   = polls_sent + PhasePolls;
         while (polls_sent < phase_end)
            gesture(tick);
         phase++;
      end
      steady_flow = 1'b0;
   endtask

   initial begin : stimulus
      int unsigned drain_wait;
      reset_gesture_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_volume_mode();
      test_play_and_station();
      test_time_wrap();
      test_register_corners();
      test_backpressure();
      test_random_gestures();
      req_valid <= 1'b0;
      drain_wait = 0;
      while (due_outcomes.size() != 0 && drain_wait < DrainLimit) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (4) @(posedge clock);
      if (due_outcomes.size() != 0) begin
         $error("%0d results never arrived", due_outcomes.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin : watchdog
      #40000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/tbgc_pkg.sv
rtl/three_button_gesture_controller.sv
bench/three_button_gesture_controller_tb.sv
